### rtl/fp16a4_pkg.sv
`default_nettype none
package fp16a4_pkg;

    localparam int HALF_W = 16;
    localparam int MAG_W = 42;
    localparam int POS_W = 6;

    localparam logic [15:0] HALF_SIGN = 16'h8000;
    localparam logic [4:0] HALF_EXP_MAX = 5'h1F;
    localparam logic [9:0] HALF_FRAC_MASK = 10'h3FF;
    localparam logic [15:0] HALF_QNAN = 16'h7E00;
    localparam logic [15:0] HALF_INF = 16'h7C00;

    typedef struct packed {
        logic nan;
        logic pinf;
        logic ninf;
        logic negz;
    } spec_t;

endpackage
`default_nettype wire

### rtl/fp16_four_input_add.sv
`default_nettype none
// four binary16 operands summed exactly and rounded once (nearest even), subnormals
// flushed, nans canonical; six register stages (decode, pair sums, total and magnitude,
// leading one search, normalise, round); a new beat is taken every cycle unless in_stall
// is high; stages with no beat fill up while the output is stalled
module fp16_four_input_add (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] operand_a,
    input  wire logic [15:0] operand_b,
    input  wire logic [15:0] operand_c,
    input  wire logic [15:0] operand_d,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      sum_bits
);
    import fp16a4_pkg::*;

    localparam int STAGES = 6;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;

    logic signed [41:0] dv_a, dv_b, dv_c, dv_d;
    spec_t              df_a, df_b, df_c, df_d;
    spec_t              spec_in;

    logic signed [41:0] s1_a_reg, s1_b_reg, s1_c_reg, s1_d_reg;
    spec_t              s1_spec_reg, s2_spec_reg, s3_spec_reg, s4_spec_reg, s5_spec_reg;
    logic signed [42:0] s2_ab_reg, s2_cd_reg;
    logic signed [42:0] total;
    logic [41:0]        s3_mag_reg, s4_mag_reg, s5_norm_reg;
    logic               s3_sign_reg, s4_sign_reg, s5_sign_reg;
    logic               s3_zero_reg, s4_zero_reg, s5_zero_reg;
    logic [5:0]         pos_next, s4_pos_reg, s5_pos_reg;
    logic [15:0]        result;
    logic [15:0]        sum_reg;

    fp16a4_decode u_dec_a (.half_in(operand_a), .value(dv_a), .flags(df_a));
    fp16a4_decode u_dec_b (.half_in(operand_b), .value(dv_b), .flags(df_b));
    fp16a4_decode u_dec_c (.half_in(operand_c), .value(dv_c), .flags(df_c));
    fp16a4_decode u_dec_d (.half_in(operand_d), .value(dv_d), .flags(df_d));

    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || !out_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
        spec_in.nan  = df_a.nan || df_b.nan || df_c.nan || df_d.nan;
        spec_in.pinf = df_a.pinf || df_b.pinf || df_c.pinf || df_d.pinf;
        spec_in.ninf = df_a.ninf || df_b.ninf || df_c.ninf || df_d.ninf;
        spec_in.negz = df_a.negz && df_b.negz && df_c.negz && df_d.negz;
        total = s2_ab_reg + s2_cd_reg;
        pos_next = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (s3_mag_reg[i])
            begin
                pos_next = POS_W'(i);
            end
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[STAGES-1];
    assign sum_bits  = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_a_reg    <= dv_a;
            s1_b_reg    <= dv_b;
            s1_c_reg    <= dv_c;
            s1_d_reg    <= dv_d;
            s1_spec_reg <= spec_in;
        end
        if (adv[1])
        begin
            s2_ab_reg   <= 43'(s1_a_reg) + 43'(s1_b_reg);
            s2_cd_reg   <= 43'(s1_c_reg) + 43'(s1_d_reg);
            s2_spec_reg <= s1_spec_reg;
        end
        if (adv[2])
        begin
            s3_sign_reg <= total[42];
            s3_zero_reg <= (total == '0);
            s3_mag_reg  <= total[42] ? 42'(-total) : total[41:0];
            s3_spec_reg <= s2_spec_reg;
        end
        if (adv[3])
        begin
            s4_mag_reg  <= s3_mag_reg;
            s4_pos_reg  <= pos_next;
            s4_sign_reg <= s3_sign_reg;
            s4_zero_reg <= s3_zero_reg;
            s4_spec_reg <= s3_spec_reg;
        end
        if (adv[4])
        begin
            s5_norm_reg <= s4_mag_reg << (6'd41 - s4_pos_reg);
            s5_pos_reg  <= s4_pos_reg;
            s5_sign_reg <= s4_sign_reg;
            s5_zero_reg <= s4_zero_reg;
            s5_spec_reg <= s4_spec_reg;
        end
        if (adv[5])
        begin
            sum_reg <= result;
        end
    end

    fp16a4_round u_round (
        .norm   (s5_norm_reg),
        .pos    (s5_pos_reg),
        .sign   (s5_sign_reg),
        .zero   (s5_zero_reg),
        .spec   (s5_spec_reg),
        .result (result)
    );

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> valid_reg[0])
        else $error("input stalled with empty first stage");

    a_beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted beat lost at first stage");

    a_no_subnormal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !((sum_bits[14:10] == 5'd0) && (sum_bits[9:0] != 10'd0)))
        else $error("subnormal result");

    a_canonical_nan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (sum_bits[14:10] == HALF_EXP_MAX) && (sum_bits[9:0] != 10'd0))
        |-> (sum_bits == HALF_QNAN))
        else $error("non canonical nan");

endmodule
`default_nettype wire

### rtl/fp16a4_decode.sv
`default_nettype none
module fp16a4_decode (
    input  wire logic [15:0]              half_in,
    output logic signed [41:0]            value,
    output fp16a4_pkg::spec_t             flags
);
    import fp16a4_pkg::*;

    logic [4:0]  expo;
    logic [9:0]  frac;
    logic [40:0] mag;

    always_comb
    begin
        expo = half_in[14:10];
        frac = half_in[9:0] & HALF_FRAC_MASK;
        flags.nan  = (expo == HALF_EXP_MAX) && (frac != 10'd0);
        flags.pinf = (expo == HALF_EXP_MAX) && (frac == 10'd0) && !half_in[15];
        flags.ninf = (expo == HALF_EXP_MAX) && (frac == 10'd0) && half_in[15];
        flags.negz = (expo == 5'd0) && half_in[15];
        if ((expo == 5'd0) || (expo == HALF_EXP_MAX))
        begin
            mag = '0;
        end
        else
        begin
            mag = {30'd0, 1'b1, frac} << (expo - 5'd1);
        end
        value = half_in[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

endmodule
`default_nettype wire

### rtl/fp16a4_round.sv
`default_nettype none
module fp16a4_round (
    input  wire logic [41:0]        norm,
    input  wire logic [5:0]         pos,
    input  wire logic               sign,
    input  wire logic               zero,
    input  wire fp16a4_pkg::spec_t  spec,
    output logic [15:0]             result
);
    import fp16a4_pkg::*;

    logic [10:0] sig;
    logic        guard;
    logic        sticky;
    logic        up;
    logic [11:0] sig_r;
    logic [5:0]  expo;
    logic [9:0]  frac;

    always_comb
    begin
        sig    = norm[41:31];
        guard  = norm[30];
        sticky = |norm[29:0];
        up     = guard && (sticky || sig[0]);
        sig_r  = {1'b0, sig} + {11'd0, up};
        expo   = pos - 6'd9;
        frac   = sig_r[9:0];
        if (sig_r[11])
        begin
            expo = expo + 6'd1;
            frac = sig_r[10:1];
        end
        priority if (spec.nan || (spec.pinf && spec.ninf))
            result = HALF_QNAN;
        else if (spec.pinf)
            result = HALF_INF;
        else if (spec.ninf)
            result = HALF_SIGN | HALF_INF;
        else if (zero)
            result = spec.negz ? HALF_SIGN : 16'h0000;
        else if (pos < 6'd10)
            result = {sign, 15'd0};
        else if (expo >= {1'b0, HALF_EXP_MAX})
            result = {sign, 15'd0} | HALF_INF;
        else
            result = {sign, expo[4:0], frac};
    end

endmodule
`default_nettype wire
